// ===== rtl/core/mrc_pkg.sv =====
// Shared constants and types for the mixed-radix index converter.
`default_nettype none
package mrc_pkg;
  localparam int unsigned NUM_DIMS       = 8;
  localparam int unsigned COORD_BITS     = 8;
  localparam int unsigned INDEX_BITS     = 32;
  localparam int unsigned RADIX_BITS     = 9;
  localparam int unsigned DIM_BITS       = $clog2(NUM_DIMS);
  localparam int unsigned BITS_PER_STEP  = 4;
  localparam int unsigned STEPS_PER_CELL = INDEX_BITS / BITS_PER_STEP;

  typedef enum logic {
    MODE_FOLD  = 1'b0,
    MODE_SPLIT = 1'b1
  } mode_e;

  typedef logic [RADIX_BITS-1:0] radix_t;
  typedef logic [DIM_BITS-1:0]   dim_t;

  // payload carried down the chain; crd holds input coordinates when folding
  // and collects remainders when splitting
  typedef struct packed {
    mode_e                                mode;
    logic [INDEX_BITS-1:0]                val;
    logic [RADIX_BITS-1:0]                rem;
    logic                                 ovf;
    logic [NUM_DIMS-1:0][COORD_BITS-1:0]  crd;
  } tok_t;

  // per-step control handed from a cell to its steps
  typedef struct packed {
    logic   first;
    logic   last;
    dim_t   fold_dim;
    dim_t   split_dim;
    radix_t fold_radix;
    radix_t split_radix;
  } step_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/mrc_step.sv =====
// One pipeline step: fold multiply-add or four bits of restoring division.
`default_nettype none
module mrc_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  mrc_pkg::step_ctl_t ctl_i,
  input  logic               valid_i,
  input  mrc_pkg::tok_t      tok_i,
  output logic               valid_o,
  output mrc_pkg::tok_t      tok_o
);
  import mrc_pkg::*;

  localparam int unsigned SUM_BITS = INDEX_BITS + RADIX_BITS;

  tok_t                  tok_d, tok_q;
  logic                  valid_q;
  radix_t                r_fold, r_split;
  logic [SUM_BITS-1:0]   sum;
  logic [RADIX_BITS-1:0] rem;
  logic [RADIX_BITS:0]   trial;
  logic [INDEX_BITS-1:0] num;

  always_comb begin
    tok_d   = tok_i;
    r_fold  = (ctl_i.fold_radix == '0) ? radix_t'(1) : ctl_i.fold_radix;
    r_split = (ctl_i.split_radix == '0) ? radix_t'(1) : ctl_i.split_radix;
    sum     = '0;
    rem     = ctl_i.first ? '0 : tok_i.rem;
    num     = tok_i.val;
    trial   = '0;
    if (tok_i.mode == MODE_FOLD) begin
      if (ctl_i.first) begin
        sum = SUM_BITS'(tok_i.val) * SUM_BITS'(r_fold)
            + SUM_BITS'(tok_i.crd[ctl_i.fold_dim]);
        tok_d.val = sum[INDEX_BITS-1:0];
        tok_d.ovf = tok_i.ovf | (|sum[SUM_BITS-1:INDEX_BITS]);
      end
    end else begin
      for (int b = 0; b < BITS_PER_STEP; b++) begin
        trial = {rem, num[INDEX_BITS-1]};
        num   = {num[INDEX_BITS-2:0], 1'b0};
        if (trial >= {1'b0, r_split}) begin
          trial  = trial - {1'b0, r_split};
          num[0] = 1'b1;
        end
        rem = trial[RADIX_BITS-1:0];
      end
      tok_d.val = num;
      tok_d.rem = rem;
      if (ctl_i.last) begin
        tok_d.crd[ctl_i.split_dim] = rem[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;
endmodule
`default_nettype wire

// ===== rtl/core/mrc_cell.sv =====
// One dimension cell: a short row of steps that handles one radix.
`default_nettype none
module mrc_cell (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  mrc_pkg::dim_t                            dim_i,
  input  logic [mrc_pkg::NUM_DIMS-1:0][mrc_pkg::RADIX_BITS-1:0] radix_i,
  input  logic                                     valid_i,
  input  mrc_pkg::tok_t                            tok_i,
  output logic                                     valid_o,
  output mrc_pkg::tok_t                            tok_o
);
  import mrc_pkg::*;

  logic [STEPS_PER_CELL:0] vld;
  tok_t                    tok [STEPS_PER_CELL+1];
  dim_t                    split_dim;

  assign split_dim = dim_t'(NUM_DIMS - 1) - dim_i;
  assign vld[0]    = valid_i;
  assign tok[0]    = tok_i;

  for (genvar s = 0; s < STEPS_PER_CELL; s++) begin : g_step
    step_ctl_t ctl;
    assign ctl.first       = (s == 0);
    assign ctl.last        = (s == STEPS_PER_CELL - 1);
    assign ctl.fold_dim    = dim_i;
    assign ctl.split_dim   = split_dim;
    assign ctl.fold_radix  = radix_i[dim_i];
    assign ctl.split_radix = radix_i[split_dim];

    mrc_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .ctl_i   (ctl),
      .valid_i (vld[s]),
      .tok_i   (tok[s]),
      .valid_o (vld[s+1]),
      .tok_o   (tok[s+1])
    );
  end

  assign valid_o = vld[STEPS_PER_CELL];
  assign tok_o   = tok[STEPS_PER_CELL];
endmodule
`default_nettype wire

// ===== rtl/core/mixed_radix_index_converter.sv =====
// Top level of the mixed-radix row-major index converter.
// Takes one request per clock while in_ready_o is high and returns one result
// per request, in order, through eight dimension cells of eight steps each. The
// first step of a cell does that dimension's fold multiply-add, and every step
// does four bits of that cell's division when splitting.
// The whole chain advances together; a stalled result at the output holds the
// chain, and in_ready_o is high whenever the output register is empty or taken.
`default_nettype none
module mixed_radix_index_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  coord_0_i,
  input  logic [7:0]  coord_1_i,
  input  logic [7:0]  coord_2_i,
  input  logic [7:0]  coord_3_i,
  input  logic [7:0]  coord_4_i,
  input  logic [7:0]  coord_5_i,
  input  logic [7:0]  coord_6_i,
  input  logic [7:0]  coord_7_i,
  input  logic [31:0] linear_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] linear_out_o,
  output logic [7:0]  split_0_o,
  output logic [7:0]  split_1_o,
  output logic [7:0]  split_2_o,
  output logic [7:0]  split_3_o,
  output logic [7:0]  split_4_o,
  output logic [7:0]  split_5_o,
  output logic [7:0]  split_6_o,
  output logic [7:0]  split_7_o,
  output logic        overflow_o
);
  import mrc_pkg::*;

  logic [NUM_DIMS-1:0][RADIX_BITS-1:0] radix_q;
  logic [NUM_DIMS:0]                   vld;
  tok_t                                tok [NUM_DIMS+1];
  tok_t                                tok_in;
  logic                                adv;
  tok_t                                res;
  logic                                split_mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIMS; i++) begin
        radix_q[i] <= radix_t'(1);
      end
    end else if (cfg_we_i) begin
      radix_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign adv        = !vld[NUM_DIMS] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    tok_in        = '0;
    tok_in.mode   = mode_e'(mode_i);
    tok_in.val    = (mode_e'(mode_i) == MODE_SPLIT) ? linear_in_i : '0;
    tok_in.crd[0] = coord_0_i;
    tok_in.crd[1] = coord_1_i;
    tok_in.crd[2] = coord_2_i;
    tok_in.crd[3] = coord_3_i;
    tok_in.crd[4] = coord_4_i;
    tok_in.crd[5] = coord_5_i;
    tok_in.crd[6] = coord_6_i;
    tok_in.crd[7] = coord_7_i;
  end
  assign tok[0] = tok_in;
  assign vld[0] = in_valid_i;

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_cell
    mrc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .dim_i   (dim_t'(d)),
      .radix_i (radix_q),
      .valid_i (vld[d]),
      .tok_i   (tok[d]),
      .valid_o (vld[d+1]),
      .tok_o   (tok[d+1])
    );
  end

  assign res        = tok[NUM_DIMS];
  assign split_mode = (res.mode == MODE_SPLIT);

  assign out_valid_o  = vld[NUM_DIMS];
  assign linear_out_o = split_mode ? '0 : res.val;
  assign overflow_o   = split_mode ? 1'b0 : res.ovf;
  assign split_0_o    = split_mode ? res.crd[0] : '0;
  assign split_1_o    = split_mode ? res.crd[1] : '0;
  assign split_2_o    = split_mode ? res.crd[2] : '0;
  assign split_3_o    = split_mode ? res.crd[3] : '0;
  assign split_4_o    = split_mode ? res.crd[4] : '0;
  assign split_5_o    = split_mode ? res.crd[5] : '0;
  assign split_6_o    = split_mode ? res.crd[6] : '0;
  assign split_7_o    = split_mode ? res.crd[7] : '0;
endmodule
`default_nettype wire

// ===== rtl/core/mrc_checker.sv =====
// Port-level checker for the index converter, bound to the top level.
`default_nettype none
module mrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] linear_out_o,
  input logic [7:0]  split_0_o,
  input logic [7:0]  split_7_o,
  input logic        overflow_o
);
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("request taken while result stalled");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(linear_out_o))
    else $error("stalled result changed");

  a_overflow_fold_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> split_0_o == 8'd0 && split_7_o == 8'd0)
    else $error("overflow on a split result");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result during reset");
endmodule

bind mixed_radix_index_converter mrc_checker u_mrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .linear_out_o (linear_out_o),
  .split_0_o    (split_0_o),
  .split_7_o    (split_7_o),
  .overflow_o   (overflow_o)
);
`default_nettype wire
